### hdl/sbp_pkg.sv
// Shared types and constants of the staggered Bezier position block.
// No dependencies; every other file imports this package.
package sbp_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STAGES = 16;

    localparam logic [2:0] REG_POINT0 = 3'd0;
    localparam logic [2:0] REG_POINT1 = 3'd1;
    localparam logic [2:0] REG_POINT2 = 3'd2;
    localparam logic [2:0] REG_POINT3 = 3'd3;
    localparam logic [2:0] REG_DEGREE = 3'd4;
    localparam logic [2:0] REG_DURATION = 3'd5;

    localparam logic [15:0] DURATION_RESET = 16'd1000;
    localparam logic [16:0] T_ONE = 17'h10000;

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic [3:0]  slot_index;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } out_t;

    typedef enum logic [2:0] {
        CLS_ZERO = 3'b001,
        CLS_ONE  = 3'b010,
        CLS_DIV  = 3'b100
    } cls_t;

    typedef struct packed {
        logic [3:0][31:0] points;
        logic [1:0]       degree;
        logic [15:0]      dur;
        logic [18:0]      den;
    } cfg_t;

    typedef struct packed {
        cls_t        cls;
        logic [18:0] rem;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### hdl/sbp_front.sv
// Front end: forms the stagger-adjusted time numerator and classifies it.
// Depends on sbp_pkg.
module sbp_front (
    input  sbp_pkg::in_t   in_data,
    input  sbp_pkg::cfg_t  cfg,
    output sbp_pkg::entry_t entry
);
    import sbp_pkg::*;

    logic [3:0]         slot_eff;
    logic [18:0]        five_e;
    logic [19:0]        slot_dur;
    logic signed [20:0] u;

    always_comb begin
        slot_eff = (int'(in_data.slot_index) >= SLOT_COUNT) ? 4'(SLOT_COUNT - 1)
                                                            : in_data.slot_index;
        five_e = {1'b0, in_data.elapsed_ms, 2'b00} + {3'b000, in_data.elapsed_ms};
        slot_dur = 20'(slot_eff) * 20'(cfg.dur);
        u = $signed({2'b00, five_e}) - $signed({1'b0, slot_dur});
        entry.rem = u[18:0];
        if (u <= 21'sd0) begin
            entry.cls = CLS_ZERO;
        end else if (u >= $signed({2'b00, cfg.den})) begin
            entry.cls = CLS_ONE;
        end else begin
            entry.cls = CLS_DIV;
        end
    end

endmodule

### hdl/sbp_queue.sv
// Short queue between front and back ends.
// Depends on sbp_pkg.
module sbp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sbp_pkg::entry_t push_data,
    input  logic            pop,
    output sbp_pkg::entry_t pop_data,
    output sbp_pkg::qstat_t stat
);
    import sbp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    entry_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
        stat.full = (count_reg == (PW+1)'(QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        pop_data = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/sbp_div.sv
// Back end, part one: pipelined restoring divider, one quotient bit per stage.
// Depends on sbp_pkg.
module sbp_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  sbp_pkg::entry_t in_entry,
    input  sbp_pkg::cfg_t   cfg,
    output logic            t_valid,
    output logic [16:0]     t_val
);
    import sbp_pkg::*;

    logic [18:0] rem_reg [DIV_STAGES+1];
    logic [15:0] q_reg   [DIV_STAGES+1];
    cls_t        cls_reg [DIV_STAGES+1];
    logic        vld_reg [DIV_STAGES+1];

    logic [19:0] r2   [DIV_STAGES];
    logic        ge   [DIV_STAGES];
    logic [19:0] diff [DIV_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            r2[k] = {rem_reg[k], 1'b0};
            ge[k] = (r2[k] >= {1'b0, cfg.den});
            diff[k] = r2[k] - {1'b0, cfg.den};
        end
        unique case (cls_reg[DIV_STAGES])
            CLS_ZERO: t_val = '0;
            CLS_ONE:  t_val = T_ONE;
            CLS_DIV:  t_val = {1'b0, q_reg[DIV_STAGES]};
            default:  t_val = '0;
        endcase
        t_valid = vld_reg[DIV_STAGES];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= in_entry.rem;
            q_reg[0] <= '0;
            cls_reg[0] <= in_entry.cls;
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k+1] <= ge[k] ? diff[k][18:0] : r2[k][18:0];
                q_reg[k+1] <= {q_reg[k][14:0], ge[k]};
                cls_reg[k+1] <= cls_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

endmodule

### hdl/sbp_poly.sv
// Back end, part two: Bernstein weights, weighted sum, rounding, saturation.
// Depends on sbp_pkg.
module sbp_poly (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          t_valid,
    input  logic [16:0]   t_val,
    input  sbp_pkg::cfg_t cfg,
    output logic          out_valid,
    output sbp_pkg::out_t out_data
);
    import sbp_pkg::*;

    logic [16:0] s1_reg, t1_reg;
    logic [33:0] ss_reg, st_reg, tt_reg;
    logic [48:0] w_reg [4];
    logic signed [65:0] px_reg [4];
    logic signed [65:0] py_reg [4];
    logic signed [65:0] ax_reg, ay_reg;
    out_t        out_reg;
    logic [4:0]  vld_reg;

    logic [16:0] s_c;
    logic [50:0] m_sss, m_sst, m_stt, m_ttt;
    logic [48:0] w_next [4];
    logic signed [65:0] rx, ry;
    logic signed [17:0] shx, shy;
    out_t        out_next;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb begin
        s_c = T_ONE - t_val;
        m_sss = 51'(ss_reg) * 51'(s1_reg);
        m_sst = 51'(ss_reg) * 51'(t1_reg);
        m_stt = 51'(st_reg) * 51'(t1_reg);
        m_ttt = 51'(tt_reg) * 51'(t1_reg);
        for (int j = 0; j < 4; j++) begin
            w_next[j] = '0;
        end
        unique case (cfg.degree)
            2'd0: begin
                w_next[0] = 49'h1_0000_0000_0000;
            end
            2'd1: begin
                w_next[0] = {s1_reg, 32'h0};
                w_next[1] = {t1_reg, 32'h0};
            end
            2'd2: begin
                w_next[0] = 49'({ss_reg, 16'h0});
                w_next[1] = 49'({st_reg, 17'h0});
                w_next[2] = 49'({tt_reg, 16'h0});
            end
            2'd3: begin
                w_next[0] = m_sss[48:0];
                w_next[1] = 49'(m_sst + {m_sst[49:0], 1'b0});
                w_next[2] = 49'(m_stt + {m_stt[49:0], 1'b0});
                w_next[3] = m_ttt[48:0];
            end
            default: begin
            end
        endcase
        rx = ax_reg + 66'sh0_8000_0000_0000;
        ry = ay_reg + 66'sh0_8000_0000_0000;
        shx = 18'(rx >>> 48);
        shy = 18'(ry >>> 48);
        out_next.pos_x = sat16(shx);
        out_next.pos_y = sat16(shy);
        out_valid = vld_reg[4];
        out_data = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s_c;
            t1_reg <= t_val;
            ss_reg <= 34'(s_c) * 34'(s_c);
            st_reg <= 34'(s_c) * 34'(t_val);
            tt_reg <= 34'(t_val) * 34'(t_val);
            for (int j = 0; j < 4; j++) begin
                w_reg[j] <= w_next[j];
                px_reg[j] <= $signed({1'b0, w_reg[j]}) * $signed(cfg.points[j][15:0]);
                py_reg[j] <= $signed({1'b0, w_reg[j]}) * $signed(cfg.points[j][31:16]);
            end
            ax_reg <= px_reg[0] + px_reg[1] + px_reg[2] + px_reg[3];
            ay_reg <= py_reg[0] + py_reg[1] + py_reg[2] + py_reg[3];
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], t_valid};
        end
    end

endmodule

### hdl/staggered_bezier_position.sv
// Staggered Bezier position: top level with configuration registers.
// Throughput: one item per cycle while the result is not stalled by m_ready;
// the 16-stage divider and the weight, product, sum and rounding stages all
// advance together on one enable.
// Reset: synchronous active-low aresetn clears queue and valid bits and
// restores registers (points 0, degree 1, duration 1000 ms).
module staggered_bezier_position (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sbp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sbp_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import sbp_pkg::*;

    cfg_t    cfg_reg;
    entry_t  f_entry, q_entry;
    qstat_t  qstat;
    logic    push, pop, adv;
    logic    t_valid;
    logic [16:0] t_val;
    logic [15:0] dur_w;

    assign cfg_ready = 1'b1;
    assign s_ready = !qstat.full;
    assign push = s_valid && s_ready;
    assign adv = !m_valid || m_ready;
    assign pop = adv && !qstat.empty;
    assign dur_w = (cfg_data[15:0] == '0) ? 16'd1 : cfg_data[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.points <= '0;
            cfg_reg.degree <= 2'd1;
            cfg_reg.dur <= DURATION_RESET;
            cfg_reg.den <= 19'(DURATION_RESET) * 19'd5;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POINT0:   cfg_reg.points[0] <= cfg_data;
                REG_POINT1:   cfg_reg.points[1] <= cfg_data;
                REG_POINT2:   cfg_reg.points[2] <= cfg_data;
                REG_POINT3:   cfg_reg.points[3] <= cfg_data;
                REG_DEGREE:   cfg_reg.degree <= cfg_data[1:0];
                REG_DURATION: begin
                    cfg_reg.dur <= dur_w;
                    cfg_reg.den <= 19'(dur_w) * 19'd5;
                end
                default: begin
                end
            endcase
        end
    end

    sbp_front u_front (
        .in_data(s_data),
        .cfg    (cfg_reg),
        .entry  (f_entry)
    );

    sbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(f_entry),
        .pop      (pop),
        .pop_data (q_entry),
        .stat     (qstat)
    );

    sbp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_valid(pop),
        .in_entry(q_entry),
        .cfg     (cfg_reg),
        .t_valid (t_valid),
        .t_val   (t_val)
    );

    sbp_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .t_valid  (t_valid),
        .t_val    (t_val),
        .cfg      (cfg_reg),
        .out_valid(m_valid),
        .out_data (m_data)
    );

    a_queue_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty at once");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("queue popped while result stalled");

    a_reject_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !push)
        else $error("transfer accepted into full queue");

endmodule

### verif/tb_staggered_bezier_position.sv
`timescale 1ns / 100ps
// Staggered Bezier position testbench: directed table, degree sweep, then random items.
// Checks every result against table values or a fixed-point curve predictor; uses sbp_pkg.
module tb_staggered_bezier_position;
    import sbp_pkg::*;

    typedef struct {
        logic [15:0] elapsed;
        logic [3:0]  slot;
        logic        known;
        logic [15:0] ex;
        logic [15:0] ey;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_POINT0;
    logic [31:0] cfg_data = '0;

    logic [31:0] curve_pts [4];
    logic [1:0]  curve_deg;
    logic [15:0] curve_dur;
    out_t        pos_queue [$];
    int          errors = 0;
    int          cycles = 0;
    bit          sink_enable = 1'b0;
    row_t        table_rows [$];

    staggered_bezier_position u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] round_pixel(logic signed [71:0] acc);
        logic signed [71:0] pix;
        begin
            pix = (acc + 72'sh0000_8000_0000_0000) >>> 48;
            if (pix > 32767) pix = 32767;
            if (pix < -32768) pix = -32768;
            return pix[15:0];
        end
    endfunction

    function automatic out_t curve_position(logic [15:0] elapsed, logic [3:0] slot_in);
        logic signed [40:0] u;
        logic [40:0]        den;
        logic [63:0]        t, s;
        logic [63:0]        w [4];
        logic signed [71:0] ax, ay;
        logic [15:0]        dur;
        out_t               r;
        begin
            dur = (curve_dur == 0) ? 16'd1 : curve_dur;
            u = 5 * $signed({25'd0, elapsed}) - $signed({37'd0, slot_in}) * $signed({25'd0, dur});
            den = 5 * dur;
            if (u <= 0) t = 0;
            else if (u >= $signed(den)) t = 65536;
            else t = ({23'd0, u} << 16) / den;
            s = 65536 - t;
            w[1] = 0; w[2] = 0; w[3] = 0;
            case (curve_deg)
                2'd0: w[0] = 64'd1 << 48;
                2'd1: begin
                    w[0] = s << 32; w[1] = t << 32;
                end
                2'd2: begin
                    w[0] = (s * s) << 16; w[1] = (2 * s * t) << 16; w[2] = (t * t) << 16;
                end
                default: begin
                    w[0] = s * s * s; w[1] = 3 * s * s * t;
                    w[2] = 3 * s * t * t; w[3] = t * t * t;
                end
            endcase
            ax = 0; ay = 0;
            for (int j = 0; j < 4; j++) begin
                ax += $signed({8'd0, w[j]}) * $signed(curve_pts[j][15:0]);
                ay += $signed({8'd0, w[j]}) * $signed(curve_pts[j][31:16]);
            end
            r.pos_x = round_pixel(ax);
            r.pos_y = round_pixel(ay);
            return r;
        end
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            case (idx)
                REG_POINT0: curve_pts[0] = val;
                REG_POINT1: curve_pts[1] = val;
                REG_POINT2: curve_pts[2] = val;
                REG_POINT3: curve_pts[3] = val;
                REG_DEGREE: curve_deg = val[1:0];
                REG_DURATION: curve_dur = val[15:0];
                default: ;
            endcase
            @(posedge aclk);
        end
    endtask

    function automatic int gap_length();
        int n;
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) n = 0;
            return n;
        end
    endfunction

    task automatic send_expect(logic [15:0] elapsed, logic [3:0] slot_in, out_t exp_pos);
        int n;
        begin
            s_valid <= 1'b1;
            s_data <= '{elapsed_ms: elapsed, slot_index: slot_in};
            pos_queue.insert(pos_queue.size(), exp_pos);
            do @(posedge aclk); while (!s_ready);
            n = gap_length();
            if (n != 0) begin
                s_valid <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    endtask

    task automatic send_item(logic [15:0] elapsed, logic [3:0] slot_in);
        begin
            send_expect(elapsed, slot_in, curve_position(elapsed, slot_in));
        end
    endtask

    task automatic add_row(logic [15:0] elapsed, logic [3:0] slot_in, logic known,
                           logic [15:0] ex, logic [15:0] ey);
        row_t r;
        begin
            r.elapsed = elapsed;
            r.slot = slot_in;
            r.known = known;
            r.ex = ex;
            r.ey = ey;
            table_rows.insert(table_rows.size(), r);
        end
    endtask

    task automatic run_table();
        begin
            foreach (table_rows[i]) begin
                if (table_rows[i].known)
                    send_expect(table_rows[i].elapsed, table_rows[i].slot,
                                '{pos_x: table_rows[i].ex, pos_y: table_rows[i].ey});
                else
                    send_item(table_rows[i].elapsed, table_rows[i].slot);
            end
        end
    endtask

    task automatic drain();
        begin
            s_valid <= 1'b0;
            while (pos_queue.size() != 0) @(posedge aclk);
            repeat (30) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pos_queue.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                out_t exp_pos;
                exp_pos = pos_queue.pop_front();
                if (m_data.pos_x !== exp_pos.pos_x) begin
                    $error("pos_x expected %0d actual %0d", exp_pos.pos_x, m_data.pos_x);
                    errors++;
                end
                if (m_data.pos_y !== exp_pos.pos_y) begin
                    $error("pos_y expected %0d actual %0d", exp_pos.pos_y, m_data.pos_y);
                    errors++;
                end
            end
        end
        if (sink_enable) begin
            if ($urandom_range(0, 19) == 0) m_ready <= 1'b0;
            else if ($urandom_range(0, 2) == 0) m_ready <= 1'b1;
        end
    end

    task automatic random_config(bit extreme);
        begin
            for (int j = 0; j < 4; j++)
                write_reg(3'(int'(REG_POINT0) + j), extreme ? ($urandom_range(0, 1) ?
                          32'h7FFF_8000 : 32'h8000_7FFF) : $urandom());
            write_reg(REG_DEGREE, $urandom_range(0, 3));
            write_reg(REG_DURATION, extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'd0)
                      : (($urandom_range(0, 1)) ? $urandom_range(1, 200)
                                                : $urandom_range(1, 65535)));
        end
    endtask

    initial begin
        curve_pts[0] = 0; curve_pts[1] = 0; curve_pts[2] = 0; curve_pts[3] = 0;
        curve_deg = 2'd1;
        curve_dur = DURATION_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset all points are zero
        add_row(16'd500, 4'd0, 1'b1, 16'd0, 16'd0);
        add_row(16'hFFFF, 4'hF, 1'b1, 16'd0, 16'd0);
        run_table();
        drain();

        write_reg(REG_POINT0, 32'h8000_7FFF);
        write_reg(REG_POINT1, 32'h7FFF_8000);
        write_reg(REG_POINT2, 32'h0064_FF9C);
        write_reg(REG_POINT3, 32'hFFFF_0001);
        table_rows.delete();
        // early clamps to first point, late to last
        add_row(16'd0, 4'd0, 1'b1, 16'h7FFF, 16'h8000);
        add_row(16'hFFFF, 4'd0, 1'b1, 16'h8000, 16'h7FFF);
        add_row(16'd100, 4'hF, 1'b1, 16'h7FFF, 16'h8000);
        add_row(16'd500, 4'd0, 1'b0, 16'd0, 16'd0);
        add_row(16'd1200, 4'd1, 1'b0, 16'd0, 16'd0);
        add_row(16'd3999, 4'd15, 1'b0, 16'd0, 16'd0);
        run_table();
        drain();
        sink_enable = 1'b1;
        for (int d = 0; d < 4; d++) begin
            write_reg(REG_DEGREE, d);
            write_reg(REG_DURATION, (d == 0) ? 16'd0 : 16'd1000);
            send_item(16'd0, 4'd0);
            send_item(16'd333, 4'd0);
            send_item(16'd2500, 4'd2);
            send_item(16'($urandom()), 4'($urandom()));
            drain();
        end

        for (int phase = 0; phase < 10; phase++) begin
            random_config(phase < 3);
            for (int i = 0; i < 75; i++) begin
                logic [15:0] span;
                span = (curve_dur == 0) ? 16'd1 : curve_dur;
                if ($urandom_range(0, 3) == 0)
                    send_item(16'($urandom()), 4'($urandom()));
                else begin
                    logic [3:0] sl;
                    sl = 4'($urandom());
                    send_item(16'(((sl + $urandom_range(0, 5)) * span) / 5
                                  + $urandom_range(0, 3)), sl);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
